FILE: rtl/compact_block_short_id_matcher_unit_assert.svh
// Assertion macros shared by the RTL.
`ifndef COMPACT_BLOCK_SHORT_ID_MATCHER_UNIT_ASSERT_SVH
`define COMPACT_BLOCK_SHORT_ID_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define CBSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cbsm assertion failed");

// Next-cycle implication.
`define CBSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cbsm assertion failed");

`endif

FILE: rtl/cbsm_pkg.sv
package cbsm_pkg;
    localparam int MAX_TX  = 4096;
    localparam int SLOT_W  = 12;
    localparam int CNT_W   = 13;
    localparam int ID_W    = 48;
    localparam int TAG_W   = 64;
    localparam int IDX_W   = 16;

    localparam logic [1:0] KIND_PREFILL = 2'd0;
    localparam logic [1:0] KIND_LOAD    = 2'd1;
    localparam logic [1:0] KIND_MEMPOOL = 2'd2;
    localparam logic [1:0] KIND_EXTRA   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FAILED  = 2'd2;

    localparam logic [2:0] OC_NONE    = 3'd0;
    localparam logic [2:0] OC_PLACED  = 3'd1;
    localparam logic [2:0] OC_MATCHED = 3'd2;
    localparam logic [2:0] OC_CLEARED = 3'd3;
    localparam logic [2:0] OC_DONE    = 3'd4;

    localparam logic CFG_SID_TOTAL = 1'b0;
    localparam logic CFG_PF_TOTAL  = 1'b1;

    typedef struct packed {
        logic pre;
        logic avail;
        logic have;
    } t_map;
endpackage

FILE: rtl/cbsm_in_if.sv
interface cbsm_in_if;
    import cbsm_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [IDX_W-1:0]  diff_index;
    logic [ID_W-1:0]   short_id;
    logic [TAG_W-1:0]  witness_tag;
    modport source (output valid, kind, diff_index, short_id, witness_tag, input ready);
    modport sink   (input valid, kind, diff_index, short_id, witness_tag, output ready);
endinterface

FILE: rtl/cbsm_out_if.sv
interface cbsm_out_if;
    import cbsm_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [IDX_W-1:0]  slot;
    logic [2:0]        outcome;
    logic [CNT_W-1:0]  matched_count;
    logic              all_matched;
    modport source (output valid, status, slot, outcome, matched_count, all_matched,
                    input ready);
    modport sink   (input valid, status, slot, outcome, matched_count, all_matched,
                    output ready);
endinterface

FILE: rtl/cbsm_ram.sv
module cbsm_ram #(
    parameter int W  = 8,
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [2**AW];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/compact_block_short_id_matcher_unit.sv
// channel   dir  modport  payload
// i_item    in   sink     kind, diff_index, short_id, witness_tag
// o_res     out  source   status, slot, outcome, matched_count, all_matched
// i_cfg_*   in   -        we / idx / data, short_id_total and prefilled_total
//
// One item at a time; the next transfer is taken once the result has left.
// Prefilled entry: slot map read-modify-write.
// Short-ID load: a slot map check of the landing slot, repeated for each prefilled
//   slot skipped, then a linear scan comparing one stored key at a time.
// Probe: linear key scan, then a slot map/tag read-modify-write.
// After reset a clearing pass sweeps all 4096 slot map entries; no
//   item is taken meanwhile, configuration writes are.
module compact_block_short_id_matcher_unit
    import cbsm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CNT_W-1:0] i_cfg_data,
    cbsm_in_if.sink          i_item,
    cbsm_out_if.source       o_res
);
`include "compact_block_short_id_matcher_unit_assert.svh"

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PF_RD  = 4'd2;
    localparam logic [3:0] S_PF_WR  = 4'd3;
    localparam logic [3:0] S_SK_RD  = 4'd4;
    localparam logic [3:0] S_SK_CHK = 4'd5;
    localparam logic [3:0] S_KY_RD  = 4'd6;
    localparam logic [3:0] S_KY_CHK = 4'd7;
    localparam logic [3:0] S_MT_RD  = 4'd8;
    localparam logic [3:0] S_MT_WR  = 4'd9;

    // control
    logic [3:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0]  r_sid, r_pft;
    logic [CNT_W-1:0]  r_last_nx, n_last_nx;   // last prefilled index + 1
    logic [CNT_W-1:0]  r_seen, n_seen;
    logic [CNT_W-1:0]  r_loaded, n_loaded;
    logic [CNT_W-1:0]  r_skip, n_skip;
    logic [CNT_W-1:0]  r_match, n_match;
    logic [1:0]        r_err, n_err;
    logic [SLOT_W+1:0] r_s, n_s;
    logic [SLOT_W-1:0] r_k, n_k;
    logic              r_out_valid, n_out_valid;
    // payload
    logic [1:0]        r_kind, n_kind;
    logic [ID_W-1:0]   r_id, n_id;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [1:0]        r_status, n_status;
    logic [IDX_W-1:0]  r_slot, n_slot;
    logic [2:0]        r_outcome, n_outcome;
    logic [CNT_W-1:0]  r_mcount, n_mcount;
    logic              r_allm, n_allm;

    // memories
    logic                   map_we, key_we, tag_we;
    logic [SLOT_W-1:0]      map_waddr, map_raddr, key_waddr, key_raddr;
    t_map                   map_wdata, map_rdata;
    logic [ID_W+SLOT_W-1:0] key_wdata, key_rdata;
    logic [TAG_W-1:0]       tag_rdata;

    cbsm_ram #(.W(3), .AW(SLOT_W)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_raddr(map_raddr), .o_rdata(map_rdata)
    );
    cbsm_ram #(.W(ID_W+SLOT_W), .AW(SLOT_W)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_waddr), .i_wdata(key_wdata),
        .i_raddr(key_raddr), .o_rdata(key_rdata)
    );
    // tag memory shares the slot map's addresses
    cbsm_ram #(.W(TAG_W), .AW(SLOT_W)) u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(map_waddr), .i_wdata(r_tag),
        .i_raddr(map_raddr), .o_rdata(tag_rdata)
    );

    logic              take;
    logic [CNT_W:0]    tot;
    logic              bad_tot;
    logic [IDX_W:0]    pos;
    logic [CNT_W:0]    pos_lim;
    logic              do_out;
    logic [1:0]        o_stat;
    logic [IDX_W-1:0]  o_slot;
    logic [2:0]        o_outc;

    assign i_item.ready = (r_state == S_IDLE) && !r_out_valid;
    assign take         = i_item.valid && i_item.ready;
    assign tot          = {1'b0, r_sid} + {1'b0, r_pft};
    assign bad_tot      = ((r_sid == '0) && (r_pft == '0)) || (tot > (CNT_W+1)'(MAX_TX));
    assign pos          = {{(IDX_W+1-CNT_W){1'b0}}, r_last_nx}
                          + {1'b0, i_item.diff_index};
    assign pos_lim      = {1'b0, r_sid} + {1'b0, r_seen};

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_last_nx   = r_last_nx;
        n_seen      = r_seen;
        n_loaded    = r_loaded;
        n_skip      = r_skip;
        n_match     = r_match;
        n_err       = r_err;
        n_s         = r_s;
        n_k         = r_k;
        n_kind      = r_kind;
        n_id        = r_id;
        n_tag       = r_tag;
        n_out_valid = r_out_valid && !o_res.ready;
        n_status    = r_status;
        n_slot      = r_slot;
        n_outcome   = r_outcome;
        n_mcount    = r_mcount;
        n_allm      = r_allm;
        map_we      = 1'b0;
        map_waddr   = r_s[SLOT_W-1:0];
        map_wdata   = map_rdata;
        map_raddr   = r_s[SLOT_W-1:0];
        key_we      = 1'b0;
        key_waddr   = r_loaded[SLOT_W-1:0];
        key_wdata   = {r_id, r_s[SLOT_W-1:0]};
        key_raddr   = r_k;
        tag_we      = 1'b0;
        do_out      = 1'b0;
        o_stat      = ST_OK;
        o_slot      = '0;
        o_outc      = OC_NONE;

        unique case (r_state)
            S_CLR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
                map_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == SLOT_W'(MAX_TX - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (take) begin
                    n_kind = i_item.kind;
                    n_id   = i_item.short_id;
                    n_tag  = i_item.witness_tag;
                    if (r_err != ST_OK) begin
                        do_out = 1'b1;
                        o_stat = r_err;
                    end else if (bad_tot) begin
                        do_out = 1'b1;
                        o_stat = ST_INVALID;
                    end else begin
                        unique case (i_item.kind)
                            KIND_PREFILL: begin
                                if ((r_seen >= r_pft) || pos[IDX_W]
                                        || (pos > {{(IDX_W-CNT_W){1'b0}}, pos_lim})
                                        || (|pos[IDX_W:SLOT_W])) begin
                                    do_out = 1'b1;
                                    o_stat = ST_INVALID;
                                end else begin
                                    n_s     = pos[SLOT_W+1:0];
                                    n_state = S_PF_RD;
                                end
                            end
                            KIND_LOAD: begin
                                if ((r_seen != r_pft) || (r_loaded >= r_sid)
                                        || r_loaded[SLOT_W]) begin
                                    do_out = 1'b1;
                                    o_stat = ST_INVALID;
                                end else begin
                                    n_s     = {1'b0, r_loaded} + {1'b0, r_skip};
                                    n_state = S_SK_RD;
                                end
                            end
                            default: begin
                                if (r_loaded != r_sid) begin
                                    do_out = 1'b1;
                                    o_stat = ST_INVALID;
                                end else if (r_match == r_sid) begin
                                    do_out = 1'b1;
                                    o_outc = OC_DONE;
                                end else begin
                                    n_k     = '0;
                                    n_state = S_KY_RD;
                                end
                            end
                        endcase
                    end
                end
            end
            S_PF_RD: begin
                n_state = S_PF_WR;
            end
            S_PF_WR: begin
                map_we    = 1'b1;
                map_wdata = '{pre: 1'b1, avail: 1'b1, have: map_rdata.have};
                n_last_nx = r_s[CNT_W-1:0] + 1'b1;
                n_seen    = r_seen + 1'b1;
                do_out    = 1'b1;
                o_slot    = {{(IDX_W-SLOT_W){1'b0}}, r_s[SLOT_W-1:0]};
                o_outc    = OC_PLACED;
                n_state   = S_IDLE;
            end
            S_SK_RD: begin
                if (|r_s[SLOT_W+1:SLOT_W]) begin
                    do_out  = 1'b1;
                    o_stat  = ST_INVALID;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SK_CHK;
                end
            end
            S_SK_CHK: begin
                if (map_rdata.pre) begin
                    n_skip  = r_skip + 1'b1;
                    n_s     = r_s + 1'b1;
                    n_state = S_SK_RD;
                end else if (r_loaded == '0) begin
                    key_we   = 1'b1;
                    n_loaded = r_loaded + 1'b1;
                    do_out   = 1'b1;
                    o_slot   = {{(IDX_W-SLOT_W){1'b0}}, r_s[SLOT_W-1:0]};
                    o_outc   = OC_PLACED;
                    n_state  = S_IDLE;
                end else begin
                    n_k     = '0;
                    n_state = S_KY_RD;
                end
            end
            S_KY_RD: begin
                n_state = S_KY_CHK;
            end
            S_KY_CHK: begin
                if (key_rdata[ID_W+SLOT_W-1:SLOT_W] == r_id) begin
                    if (r_kind == KIND_LOAD) begin
                        do_out  = 1'b1;
                        o_stat  = ST_FAILED;
                        n_state = S_IDLE;
                    end else begin
                        n_s     = {2'b00, key_rdata[SLOT_W-1:0]};
                        n_state = S_MT_RD;
                    end
                end else if (({1'b0, r_k} + 1'b1) == r_loaded) begin
                    // no key matched
                    do_out  = 1'b1;
                    n_state = S_IDLE;
                    if (r_kind == KIND_LOAD) begin
                        key_we   = 1'b1;
                        n_loaded = r_loaded + 1'b1;
                        o_slot   = {{(IDX_W-SLOT_W){1'b0}}, r_s[SLOT_W-1:0]};
                        o_outc   = OC_PLACED;
                    end
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_KY_RD;
                end
            end
            S_MT_RD: begin
                n_state = S_MT_WR;
            end
            S_MT_WR: begin
                do_out  = 1'b1;
                o_slot  = {{(IDX_W-SLOT_W){1'b0}}, r_s[SLOT_W-1:0]};
                n_state = S_IDLE;
                if (!map_rdata.have) begin
                    map_we    = 1'b1;
                    tag_we    = 1'b1;
                    map_wdata = '{pre: map_rdata.pre, avail: 1'b1, have: 1'b1};
                    n_match   = r_match + 1'b1;
                    o_outc    = OC_MATCHED;
                end else if (map_rdata.avail
                        && ((r_kind == KIND_MEMPOOL) || (tag_rdata != r_tag))) begin
                    map_we    = 1'b1;
                    map_wdata = '{pre: map_rdata.pre, avail: 1'b0, have: 1'b1};
                    if (r_match != '0) begin
                        n_match = r_match - 1'b1;
                    end
                    o_outc = OC_CLEARED;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_out) begin
            n_out_valid = 1'b1;
            n_status    = o_stat;
            n_slot      = (o_stat != ST_OK) ? '0 : o_slot;
            n_outcome   = (o_stat != ST_OK) ? OC_NONE : o_outc;
            n_mcount    = n_match;
            n_allm      = (n_loaded == r_sid) && (n_match == r_sid);
            if (o_stat != ST_OK) begin
                n_err = o_stat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_sid       <= '0;
            r_pft       <= '0;
            r_last_nx   <= '0;
            r_seen      <= '0;
            r_loaded    <= '0;
            r_skip      <= '0;
            r_match     <= '0;
            r_err       <= ST_OK;
            r_s         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_last_nx   <= n_last_nx;
            r_seen      <= n_seen;
            r_loaded    <= n_loaded;
            r_skip      <= n_skip;
            r_match     <= n_match;
            r_err       <= n_err;
            r_s         <= n_s;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SID_TOTAL: r_sid <= i_cfg_data;
                    CFG_PF_TOTAL:  r_pft <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_id      <= n_id;
        r_tag     <= n_tag;
        r_status  <= n_status;
        r_slot    <= n_slot;
        r_outcome <= n_outcome;
        r_mcount  <= n_mcount;
        r_allm    <= n_allm;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_status;
    assign o_res.slot          = r_slot;
    assign o_res.outcome       = r_outcome;
    assign o_res.matched_count = r_mcount;
    assign o_res.all_matched   = r_allm;

    // busy states never take a transfer
    `CBSM_ASSERT_NOW(a_busy_no_take, r_state != S_IDLE, !i_item.ready)
    // a latched error never goes away
    `CBSM_ASSERT_NEXT(a_err_sticky, r_err != ST_OK, r_err == $past(r_err))
    // error results carry no slot and no outcome
    `CBSM_ASSERT_NOW(a_err_clean, r_out_valid && (r_status != ST_OK),
                     (r_slot == '0) && (r_outcome == OC_NONE))
    // a key scan never runs past the loaded keys
    `CBSM_ASSERT_NOW(a_scan_bound, r_state == S_KY_CHK, {1'b0, r_k} < r_loaded)
endmodule
